// File: hdl/cpcr_pkg.sv
// cpcr_pkg: shared types, widths, register codes and helpers for the
// circle pair collision resolver. No dependencies.
`default_nettype none

package cpcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COEF_BITS = 16;
    localparam int ADDR_W    = 4;

    // normal quotient and signed normal
    localparam int QW    = FRAC_BITS + 1;
    localparam int NW    = FRAC_BITS + 2;
    localparam int RW    = FRAC_BITS + 32;
    // velocity along normal
    localparam int PXW   = 33 + NW;
    localparam int PW    = PXW + 1;
    localparam int VW    = PW - FRAC_BITS;
    // impulse
    localparam int COEFW = COEF_BITS + 2;
    localparam int JPW   = COEFW + VW;
    localparam int JW    = JPW - (COEF_BITS + 1);
    localparam int IXPW  = JW + 1 + NW;
    localparam int IXW   = IXPW - FRAC_BITS;
    // position correction
    localparam int CPW   = 33 + 17;
    localparam int CW    = CPW - (COEF_BITS + 1);
    localparam int CXPW  = NW + CW + 1;
    localparam int CXW   = CXPW - FRAC_BITS;
    localparam int SATW  = 48;

    typedef enum logic [1:0] {
        REG_RESTITUTION = 2'd0,
        REG_CORR_FRAC   = 2'd1,
        REG_PEN_SLOP    = 2'd2,
        REG_MIN_DIST    = 2'd3
    } reg_idx_t;

    localparam logic [16:0] RESTITUTION_RST = 17'd32768;
    localparam logic [16:0] CORR_FRAC_RST   = 17'd13107;
    localparam logic [20:0] PEN_SLOP_RST    = 21'd655;
    localparam logic [16:0] MIN_DIST_RST    = 17'd7;

    typedef struct packed {
        logic signed [31:0] pos_x_a;
        logic signed [31:0] pos_y_a;
        logic signed [31:0] vel_x_a;
        logic signed [31:0] vel_y_a;
        logic        [30:0] rad_a;
        logic signed [31:0] pos_x_b;
        logic signed [31:0] pos_y_b;
        logic signed [31:0] vel_x_b;
        logic signed [31:0] vel_y_b;
        logic        [30:0] rad_b;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x_a;
        logic signed [31:0] new_pos_y_a;
        logic signed [31:0] new_vel_x_a;
        logic signed [31:0] new_vel_y_a;
        logic signed [31:0] new_pos_x_b;
        logic signed [31:0] new_pos_y_b;
        logic signed [31:0] new_vel_x_b;
        logic signed [31:0] new_vel_y_b;
        logic               overlapping;
        logic               impulse_applied;
        logic               position_corrected;
    } out_word_t;

    typedef struct packed {
        in_word_t           item;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic        [31:0] rs;
        logic        [31:0] adx;
        logic        [31:0] ady;
        logic               neg_x;
        logic               neg_y;
        logic               ovl;
    } sq_side_t;

    typedef struct packed {
        in_word_t           item;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic signed [33:0] pen;
        logic               neg_x;
        logic               neg_y;
        logic               ovl;
    } dv_side_t;

    function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
        logic signed [31:0] r;
        if ((&v[SATW-1:31]) || !(|v[SATW-1:31])) begin
            r = v[31:0];
        end else if (v[SATW-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/cpcr_sqrt.sv
// cpcr_sqrt: pipelined floor square root of a 64-bit value, one result bit
// per stage, with a sideband word. Depends on cpcr_pkg.
`default_nettype none

module cpcr_sqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [63:0]        in_v,
    input  cpcr_pkg::sq_side_t in_side,
    output logic               out_valid,
    output logic [31:0]        out_root,
    output cpcr_pkg::sq_side_t out_side
);
    import cpcr_pkg::*;

    localparam int STEPS = 32;

    logic        valid_reg [1:STEPS];
    logic [63:0] v_reg     [1:STEPS];
    logic [63:0] res_reg   [1:STEPS];
    sq_side_t    side_reg  [1:STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam logic [63:0] STEP_BIT = 64'd1 << (2 * (STEPS - 1 - s));
        logic        valid_cur;
        logic [63:0] v_cur;
        logic [63:0] res_cur;
        sq_side_t    side_cur;
        logic [64:0] trial;
        logic        ge;

        if (s == 0) begin : g_first
            assign valid_cur = in_valid;
            assign v_cur     = in_v;
            assign res_cur   = '0;
            assign side_cur  = in_side;
        end else begin : g_rest
            assign valid_cur = valid_reg[s];
            assign v_cur     = v_reg[s];
            assign res_cur   = res_reg[s];
            assign side_cur  = side_reg[s];
        end

        assign trial = {1'b0, res_cur} + {1'b0, STEP_BIT};
        assign ge    = ({1'b0, v_cur} >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s+1] <= 1'b0;
            end else if (en) begin
                valid_reg[s+1] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[s+1]    <= ge ? (v_cur - trial[63:0]) : v_cur;
                res_reg[s+1]  <= ge ? ((res_cur >> 1) + STEP_BIT) : (res_cur >> 1);
                side_reg[s+1] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_root  = res_reg[STEPS][31:0];
    assign out_side  = side_reg[STEPS];

endmodule

`default_nettype wire

// File: hdl/cpcr_div.sv
// cpcr_div: pipelined restoring divider forming both normal components,
// one quotient bit per stage, with a sideband word. Depends on cpcr_pkg.
`default_nettype none

module cpcr_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [31:0]             in_ax,
    input  logic [31:0]             in_ay,
    input  logic [31:0]             in_den,
    input  cpcr_pkg::dv_side_t      in_side,
    output logic                    out_valid,
    output logic [cpcr_pkg::QW-1:0] out_qx,
    output logic [cpcr_pkg::QW-1:0] out_qy,
    output cpcr_pkg::dv_side_t      out_side
);
    import cpcr_pkg::*;

    logic          valid_reg [1:QW];
    logic [RW-1:0] rx_reg    [1:QW];
    logic [RW-1:0] ry_reg    [1:QW];
    logic [QW-1:0] qx_reg    [1:QW];
    logic [QW-1:0] qy_reg    [1:QW];
    logic [31:0]   den_reg   [1:QW];
    dv_side_t      side_reg  [1:QW];

    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int SH = QW - 1 - s;
        logic          valid_cur;
        logic [RW-1:0] rx_cur;
        logic [RW-1:0] ry_cur;
        logic [QW-1:0] qx_cur;
        logic [QW-1:0] qy_cur;
        logic [31:0]   den_cur;
        dv_side_t      side_cur;
        logic [RW-1:0] den_sh;
        logic          gex;
        logic          gey;

        if (s == 0) begin : g_first
            assign valid_cur = in_valid;
            assign rx_cur    = {in_ax, {FRAC_BITS{1'b0}}};
            assign ry_cur    = {in_ay, {FRAC_BITS{1'b0}}};
            assign qx_cur    = '0;
            assign qy_cur    = '0;
            assign den_cur   = in_den;
            assign side_cur  = in_side;
        end else begin : g_rest
            assign valid_cur = valid_reg[s];
            assign rx_cur    = rx_reg[s];
            assign ry_cur    = ry_reg[s];
            assign qx_cur    = qx_reg[s];
            assign qy_cur    = qy_reg[s];
            assign den_cur   = den_reg[s];
            assign side_cur  = side_reg[s];
        end

        assign den_sh = RW'(den_cur) << SH;
        assign gex    = (rx_cur >= den_sh);
        assign gey    = (ry_cur >= den_sh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s+1] <= 1'b0;
            end else if (en) begin
                valid_reg[s+1] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rx_reg[s+1]   <= gex ? (rx_cur - den_sh) : rx_cur;
                ry_reg[s+1]   <= gey ? (ry_cur - den_sh) : ry_cur;
                qx_reg[s+1]   <= {qx_cur[QW-2:0], gex};
                qy_reg[s+1]   <= {qy_cur[QW-2:0], gey};
                den_reg[s+1]  <= den_cur;
                side_reg[s+1] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_qx    = qx_reg[QW];
    assign out_qy    = qy_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

`default_nettype wire

// File: hdl/circle_pair_collision_resolve.sv
// circle_pair_collision_resolve: top level with the register port, front
// overlap stages, distance clamp and impulse/correction stages.
// Depends on cpcr_pkg, cpcr_sqrt and cpcr_div.
//
// Usage:
//   s_valid/s_ready/s_data carry one circle pair per word; m_valid/m_ready/
//   m_data carry the resolved pair and the three flags.
//   A new word is taken every cycle while s_ready is high. The depth is set
//   by the 32-stage square root and the 17-stage normal divider, each
//   resolving one bit per stage.
//   All stages move together: when m_valid is high and m_ready low the whole
//   pipeline holds and s_ready drops, so nothing is lost or repeated.
//   Reset clears all stage valid bits and loads the register defaults
//   (restitution 0.5, correction 0.2, slop 655, min distance 7).
//   Registers sit at byte addresses 0, 4, 8, 12 on the APB-style port;
//   pready is always high. Change them only while the pipeline is empty.
`default_nettype none

module circle_pair_collision_resolve (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cpcr_pkg::in_word_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cpcr_pkg::out_word_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpcr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cpcr_pkg::*;

    // register port
    logic [16:0] restitution_reg;
    logic [16:0] corr_frac_reg;
    logic [20:0] pen_slop_reg;
    logic [16:0] min_dist_reg;
    reg_idx_t    reg_sel;

    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restitution_reg <= RESTITUTION_RST;
            corr_frac_reg   <= CORR_FRAC_RST;
            pen_slop_reg    <= PEN_SLOP_RST;
            min_dist_reg    <= MIN_DIST_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_RESTITUTION: restitution_reg <= pwdata[16:0];
                REG_CORR_FRAC:   corr_frac_reg   <= pwdata[16:0];
                REG_PEN_SLOP:    pen_slop_reg    <= pwdata[20:0];
                REG_MIN_DIST:    min_dist_reg    <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_RESTITUTION: prdata = {15'd0, restitution_reg};
            REG_CORR_FRAC:   prdata = {15'd0, corr_frac_reg};
            REG_PEN_SLOP:    prdata = {11'd0, pen_slop_reg};
            REG_MIN_DIST:    prdata = {15'd0, min_dist_reg};
            default:         prdata = '0;
        endcase
    end

    // global advance
    logic      en;
    logic      m_valid_reg;
    out_word_t m_data_reg;

    assign en      = m_ready || !m_valid_reg;
    assign s_ready = en;

    // front: differences
    logic               f0_valid_reg;
    in_word_t           f0_item_reg;
    logic signed [32:0] f0_dx_reg, f0_dy_reg, f0_dvx_reg, f0_dvy_reg;
    logic        [31:0] f0_rs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_valid_reg <= 1'b0;
        end else if (en) begin
            f0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f0_item_reg <= s_data;
            f0_dx_reg   <= 33'(s_data.pos_x_b) - 33'(s_data.pos_x_a);
            f0_dy_reg   <= 33'(s_data.pos_y_b) - 33'(s_data.pos_y_a);
            f0_dvx_reg  <= 33'(s_data.vel_x_b) - 33'(s_data.vel_x_a);
            f0_dvy_reg  <= 33'(s_data.vel_y_b) - 33'(s_data.vel_y_a);
            f0_rs_reg   <= 32'(s_data.rad_a) + 32'(s_data.rad_b);
        end
    end

    // front: magnitudes
    logic        f1_valid_reg;
    sq_side_t    f1_side_reg;
    logic [32:0] f1_adx_reg, f1_ady_reg;
    sq_side_t    f1_side_next;
    logic [32:0] f1_adx_next, f1_ady_next;

    always_comb begin
        f1_adx_next        = f0_dx_reg[32] ? 33'(-f0_dx_reg) : 33'(f0_dx_reg);
        f1_ady_next        = f0_dy_reg[32] ? 33'(-f0_dy_reg) : 33'(f0_dy_reg);
        f1_side_next.item  = f0_item_reg;
        f1_side_next.dvx   = f0_dvx_reg;
        f1_side_next.dvy   = f0_dvy_reg;
        f1_side_next.rs    = f0_rs_reg;
        f1_side_next.adx   = f1_adx_next[31:0];
        f1_side_next.ady   = f1_ady_next[31:0];
        f1_side_next.neg_x = f0_dx_reg[32];
        f1_side_next.neg_y = f0_dy_reg[32];
        f1_side_next.ovl   = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= f0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_side_reg <= f1_side_next;
            f1_adx_reg  <= f1_adx_next;
            f1_ady_reg  <= f1_ady_next;
        end
    end

    // front: squares
    logic        f2_valid_reg;
    sq_side_t    f2_side_reg;
    logic        f2_in_range_reg;
    logic [63:0] f2_sx_reg, f2_sy_reg, f2_rs2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
        end else if (en) begin
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_side_reg     <= f1_side_reg;
            f2_in_range_reg <= (f1_adx_reg < {1'b0, f1_side_reg.rs})
                            && (f1_ady_reg < {1'b0, f1_side_reg.rs});
            f2_sx_reg       <= 64'(f1_side_reg.adx) * 64'(f1_side_reg.adx);
            f2_sy_reg       <= 64'(f1_side_reg.ady) * 64'(f1_side_reg.ady);
            f2_rs2_reg      <= 64'(f1_side_reg.rs) * 64'(f1_side_reg.rs);
        end
    end

    // front: overlap test
    logic        f3_valid_reg;
    sq_side_t    f3_side_reg;
    logic [63:0] f3_d2_reg;
    logic [64:0] f3_d2_next;
    sq_side_t    f3_side_next;

    always_comb begin
        f3_d2_next       = {1'b0, f2_sx_reg} + {1'b0, f2_sy_reg};
        f3_side_next     = f2_side_reg;
        f3_side_next.ovl = f2_in_range_reg && (f3_d2_next < {1'b0, f2_rs2_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f3_valid_reg <= 1'b0;
        end else if (en) begin
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_side_reg <= f3_side_next;
            f3_d2_reg   <= f3_d2_next[63:0];
        end
    end

    // distance
    logic        sq_valid;
    logic [31:0] sq_root;
    sq_side_t    sq_side;

    cpcr_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f3_valid_reg),
        .in_v      (f3_d2_reg),
        .in_side   (f3_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // near-zero clamp and penetration
    logic        c_valid_reg;
    logic [31:0] c_ax_reg, c_ay_reg, c_den_reg;
    dv_side_t    c_side_reg;
    logic [16:0] c_md;
    logic        c_near_zero;
    logic [31:0] c_den_next;
    dv_side_t    c_side_next;

    always_comb begin
        c_md              = (min_dist_reg == 17'd0) ? 17'd1 : min_dist_reg;
        c_near_zero       = (sq_root < 32'(c_md));
        c_den_next        = c_near_zero ? 32'(c_md) : sq_root;
        c_side_next.item  = sq_side.item;
        c_side_next.dvx   = sq_side.dvx;
        c_side_next.dvy   = sq_side.dvy;
        c_side_next.pen   = $signed(34'(sq_side.rs) - 34'(c_den_next));
        c_side_next.neg_x = c_near_zero ? 1'b0 : sq_side.neg_x;
        c_side_next.neg_y = c_near_zero ? 1'b0 : sq_side.neg_y;
        c_side_next.ovl   = sq_side.ovl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_ax_reg   <= c_near_zero ? 32'(c_md) : sq_side.adx;
            c_ay_reg   <= c_near_zero ? 32'd0 : sq_side.ady;
            c_den_reg  <= c_den_next;
            c_side_reg <= c_side_next;
        end
    end

    // normal
    logic          dv_valid;
    logic [QW-1:0] dv_qx, dv_qy;
    dv_side_t      dv_side;

    cpcr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_ax     (c_ax_reg),
        .in_ay     (c_ay_reg),
        .in_den    (c_den_reg),
        .in_side   (c_side_reg),
        .out_valid (dv_valid),
        .out_qx    (dv_qx),
        .out_qy    (dv_qy),
        .out_side  (dv_side)
    );

    // p0: signed normal, correction decision
    logic                 p0_valid_reg;
    dv_side_t             p0_side_reg;
    logic signed [NW-1:0] p0_nx_reg, p0_ny_reg;
    logic                 p0_cor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
        end else if (en) begin
            p0_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_side_reg <= dv_side;
            p0_nx_reg   <= dv_side.neg_x ? -NW'(dv_qx) : NW'(dv_qx);
            p0_ny_reg   <= dv_side.neg_y ? -NW'(dv_qy) : NW'(dv_qy);
            p0_cor_reg  <= dv_side.ovl && (dv_side.pen > $signed(34'(pen_slop_reg)));
        end
    end

    // p1: products along the normal
    logic                  p1_valid_reg;
    in_word_t              p1_item_reg;
    logic                  p1_ovl_reg, p1_cor_reg;
    logic signed [NW-1:0]  p1_nx_reg, p1_ny_reg;
    logic signed [PXW-1:0] p1_px_reg, p1_py_reg;
    logic        [CPW-1:0] p1_cp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= p0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_item_reg <= p0_side_reg.item;
            p1_ovl_reg  <= p0_side_reg.ovl;
            p1_cor_reg  <= p0_cor_reg;
            p1_nx_reg   <= p0_nx_reg;
            p1_ny_reg   <= p0_ny_reg;
            p1_px_reg   <= PXW'(p0_side_reg.dvx) * PXW'(p0_nx_reg);
            p1_py_reg   <= PXW'(p0_side_reg.dvy) * PXW'(p0_ny_reg);
            p1_cp_reg   <= CPW'(p0_side_reg.pen[32:0]) * CPW'(corr_frac_reg);
        end
    end

    // p2: approach speed, correction depth
    logic                 p2_valid_reg;
    in_word_t             p2_item_reg;
    logic                 p2_ovl_reg, p2_cor_reg, p2_imp_reg;
    logic signed [NW-1:0] p2_nx_reg, p2_ny_reg;
    logic        [VW-1:0] p2_nvan_reg;
    logic        [CW-1:0] p2_c_reg;
    logic signed [PW-1:0] p2_sum;
    logic signed [VW-1:0] p2_van;
    logic signed [VW:0]   p2_nvan;

    always_comb begin
        p2_sum  = PW'(p1_px_reg) + PW'(p1_py_reg);
        p2_van  = p2_sum[PW-1:FRAC_BITS];
        p2_nvan = -((VW+1)'(p2_van));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_item_reg <= p1_item_reg;
            p2_ovl_reg  <= p1_ovl_reg;
            p2_cor_reg  <= p1_cor_reg;
            p2_imp_reg  <= p1_ovl_reg && !p2_nvan[VW];
            p2_nx_reg   <= p1_nx_reg;
            p2_ny_reg   <= p1_ny_reg;
            p2_nvan_reg <= p2_nvan[VW-1:0];
            p2_c_reg    <= p1_cp_reg[CPW-1:COEF_BITS+1];
        end
    end

    // p3: impulse magnitude and correction vector products
    logic                   p3_valid_reg;
    in_word_t               p3_item_reg;
    logic                   p3_ovl_reg, p3_cor_reg, p3_imp_reg;
    logic signed [NW-1:0]   p3_nx_reg, p3_ny_reg;
    logic        [JPW-1:0]  p3_jp_reg;
    logic signed [CXPW-1:0] p3_cxp_reg, p3_cyp_reg;
    logic        [COEFW-1:0] p3_coef;

    assign p3_coef = COEFW'(restitution_reg) + (COEFW'(1) << COEF_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_item_reg <= p2_item_reg;
            p3_ovl_reg  <= p2_ovl_reg;
            p3_cor_reg  <= p2_cor_reg;
            p3_imp_reg  <= p2_imp_reg;
            p3_nx_reg   <= p2_nx_reg;
            p3_ny_reg   <= p2_ny_reg;
            p3_jp_reg   <= JPW'(p3_coef) * JPW'(p2_nvan_reg);
            p3_cxp_reg  <= CXPW'(p2_nx_reg) * CXPW'($signed({1'b0, p2_c_reg}));
            p3_cyp_reg  <= CXPW'(p2_ny_reg) * CXPW'($signed({1'b0, p2_c_reg}));
        end
    end

    // p4: corrected positions
    logic                  p4_valid_reg;
    out_word_t             p4_word_reg;
    logic signed [NW-1:0]  p4_nx_reg, p4_ny_reg;
    logic        [JW-1:0]  p4_j_reg;
    logic signed [CXW-1:0] p4_cx, p4_cy;
    out_word_t             p4_word_next;

    always_comb begin
        p4_cx = p3_cxp_reg[CXPW-1:FRAC_BITS];
        p4_cy = p3_cyp_reg[CXPW-1:FRAC_BITS];
        p4_word_next.new_vel_x_a = p3_item_reg.vel_x_a;
        p4_word_next.new_vel_y_a = p3_item_reg.vel_y_a;
        p4_word_next.new_vel_x_b = p3_item_reg.vel_x_b;
        p4_word_next.new_vel_y_b = p3_item_reg.vel_y_b;
        if (p3_cor_reg) begin
            p4_word_next.new_pos_x_a = sat32(SATW'(p3_item_reg.pos_x_a) - SATW'(p4_cx));
            p4_word_next.new_pos_y_a = sat32(SATW'(p3_item_reg.pos_y_a) - SATW'(p4_cy));
            p4_word_next.new_pos_x_b = sat32(SATW'(p3_item_reg.pos_x_b) + SATW'(p4_cx));
            p4_word_next.new_pos_y_b = sat32(SATW'(p3_item_reg.pos_y_b) + SATW'(p4_cy));
        end else begin
            p4_word_next.new_pos_x_a = p3_item_reg.pos_x_a;
            p4_word_next.new_pos_y_a = p3_item_reg.pos_y_a;
            p4_word_next.new_pos_x_b = p3_item_reg.pos_x_b;
            p4_word_next.new_pos_y_b = p3_item_reg.pos_y_b;
        end
        p4_word_next.overlapping        = p3_ovl_reg;
        p4_word_next.impulse_applied    = p3_imp_reg;
        p4_word_next.position_corrected = p3_cor_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_word_reg <= p4_word_next;
            p4_nx_reg   <= p3_nx_reg;
            p4_ny_reg   <= p3_ny_reg;
            p4_j_reg    <= p3_jp_reg[JPW-1:COEF_BITS+1];
        end
    end

    // p5: impulse vector products
    logic                   p5_valid_reg;
    out_word_t              p5_word_reg;
    logic signed [IXPW-1:0] p5_ixp_reg, p5_iyp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_valid_reg <= 1'b0;
        end else if (en) begin
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_word_reg <= p4_word_reg;
            p5_ixp_reg  <= IXPW'($signed({1'b0, p4_j_reg})) * IXPW'(p4_nx_reg);
            p5_iyp_reg  <= IXPW'($signed({1'b0, p4_j_reg})) * IXPW'(p4_ny_reg);
        end
    end

    // p6: velocities, output register
    logic signed [IXW-1:0] p6_ix, p6_iy;
    out_word_t             p6_word_next;

    always_comb begin
        p6_ix        = p5_ixp_reg[IXPW-1:FRAC_BITS];
        p6_iy        = p5_iyp_reg[IXPW-1:FRAC_BITS];
        p6_word_next = p5_word_reg;
        if (p5_word_reg.impulse_applied) begin
            p6_word_next.new_vel_x_a = sat32(SATW'(p5_word_reg.new_vel_x_a) - SATW'(p6_ix));
            p6_word_next.new_vel_y_a = sat32(SATW'(p5_word_reg.new_vel_y_a) - SATW'(p6_iy));
            p6_word_next.new_vel_x_b = sat32(SATW'(p5_word_reg.new_vel_x_b) + SATW'(p6_ix));
            p6_word_next.new_vel_y_b = sat32(SATW'(p5_word_reg.new_vel_y_b) + SATW'(p6_iy));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= p6_word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_imp_needs_ovl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_data_reg.impulse_applied || m_data_reg.overlapping))
        else $error("impulse flagged without overlap");

    a_cor_needs_ovl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_data_reg.position_corrected || m_data_reg.overlapping))
        else $error("correction flagged without overlap");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(f0_valid_reg) && $stable(sq_valid) && $stable(dv_valid)))
        else $error("pipeline moved during stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("output valid after reset");

endmodule

`default_nettype wire
